@@ src/cfba_pkg.sv @@
// Shared constants, types and codes for the contiguous frame bitmap allocator.
package cfba_pkg;

    localparam int MAX_FRAMES  = 4096;
    localparam int FRAME_BYTES = 4096;
    localparam int FRAME_SHIFT = $clog2(FRAME_BYTES);
    localparam int WORD_BITS   = 32;
    localparam int WORD_IW     = $clog2(WORD_BITS);
    localparam int WORDS       = MAX_FRAMES / WORD_BITS;
    localparam int WORD_AW     = $clog2(WORDS);
    localparam int FRAME_IW    = $clog2(MAX_FRAMES);
    localparam int CNT_W       = 13;
    localparam int ADDR_W      = 32;
    localparam int OUT_ADDR_W  = 31;
    localparam int FIDX_W      = ADDR_W - 1 - FRAME_SHIFT;
    localparam int CFG_IDX_W   = 2;

    localparam logic [ADDR_W-1:0] KERNEL_BIT    = 32'h8000_0000;
    localparam logic [ADDR_W-1:0] BASE_RESET    = 32'h8000_0000;
    localparam logic [CNT_W-1:0]  FCOUNT_RESET  = 13'd4096;
    localparam logic [CNT_W-1:0]  MAX_FRAMES_C  = CNT_W'(MAX_FRAMES);

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_BASE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FCOUNT = 2'd1;

    typedef enum logic [1:0] {
        STAT_OK       = 2'd0,
        STAT_NOMEM    = 2'd1,
        STAT_BADADDR  = 2'd2,
        STAT_NOTALLOC = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SCAN,
        ST_RNG_RD,
        ST_RNG_OP,
        ST_RESP
    } state_t;

    typedef enum logic [1:0] {
        RNG_CHECK,
        RNG_SET,
        RNG_CLEAR
    } rng_mode_t;

    typedef struct packed {
        logic                 rd_en;
        logic [WORD_AW-1:0]   rd_addr;
        logic                 wr_en;
        logic [WORD_AW-1:0]   wr_addr;
        logic [WORD_BITS-1:0] wr_data;
    } mem_req_t;

    typedef struct packed {
        logic               hit;
        logic [WORD_IW-1:0] hit_pos;
        logic               all_free;
        logic [WORD_IW:0]   tail_run;
    } run_res_t;

endpackage

@@ src/cfba_bitmap_ram.sv @@
// Bitmap storage: one word per 32 frames, one write and one registered read port.
module cfba_bitmap_ram (
    input  logic                        aclk,
    input  cfba_pkg::mem_req_t          req,
    output logic [cfba_pkg::WORD_BITS-1:0] rd_data
);
    import cfba_pkg::*;

    logic [WORD_BITS-1:0] mem [WORDS];

    always_ff @(posedge aclk) begin
        if (req.wr_en) begin
            mem[req.wr_addr] <= req.wr_data;
        end
        if (req.rd_en) begin
            rd_data <= mem[req.rd_addr];
        end
    end

endmodule

@@ src/cfba_run_finder.sv @@
// Word-wide first-fit unit: finds the lowest frame that completes a free run.
module cfba_run_finder (
    input  logic [cfba_pkg::WORD_BITS-1:0] used,
    input  logic [cfba_pkg::CNT_W-1:0]     run_in,
    input  logic [cfba_pkg::CNT_W-1:0]     count,
    output cfba_pkg::run_res_t             res
);
    import cfba_pkg::*;

    logic [WORD_BITS-1:0] hit_vec;

    // Each bit position checks its own window; no dependence between positions.
    always_comb begin
        logic [WORD_BITS-1:0] win;
        logic [WORD_IW-1:0]   start;
        logic [CNT_W:0]       reach;
        hit_vec = '0;
        win     = '0;
        start   = '0;
        reach   = '0;
        for (int i = 0; i < WORD_BITS; i++) begin
            if (count <= CNT_W'(i + 1)) begin
                start = WORD_IW'(CNT_W'(i + 1) - count);
                win   = ({WORD_BITS{1'b1}} << start) & ({WORD_BITS{1'b1}} >> (WORD_BITS - 1 - i));
                hit_vec[i] = ~|(used & win);
            end else begin
                win   = {WORD_BITS{1'b1}} >> (WORD_BITS - 1 - i);
                reach = {1'b0, run_in} + (CNT_W + 1)'(i + 1);
                hit_vec[i] = ~|(used & win) && (reach >= {1'b0, count});
            end
        end
    end

    always_comb begin
        res.hit      = |hit_vec;
        res.hit_pos  = '0;
        for (int i = WORD_BITS - 1; i >= 0; i--) begin
            if (hit_vec[i]) begin
                res.hit_pos = WORD_IW'(i);
            end
        end
        res.all_free = ~|used;
        // free frames above the highest used bit carry into the next word
        res.tail_run = (WORD_IW + 1)'(WORD_BITS);
        for (int i = 0; i < WORD_BITS; i++) begin
            if (used[i]) begin
                res.tail_run = (WORD_IW + 1)'(WORD_BITS - 1 - i);
            end
        end
    end

endmodule

@@ src/contiguous_frame_bitmap_allocator.sv @@
// Top level: first-fit contiguous frame allocator over a word-organized bitmap.
//
//  Channel   Dir  Ports                                   Transfer
//  s_        in   s_op, s_count, s_address                s_valid & s_ready
//  m_        out  m_status, m_frame_address               m_valid & m_ready
//  cfg_      in   cfg_index, cfg_data                     cfg_valid & cfg_ready
//
// After reset the bitmap RAM is swept to zero word by word; s_ready stays low meanwhile.
// Allocate: after the accept, the scan streams one bitmap word a cycle through the single
// run-finder unit; each marked word is then read and written back, then the result is loaded.
// Free: after the accept, each word is read for the in-use check, then each is read and cleared,
// then the result is loaded. Early errors go straight to the result. One item at a time; the
// result register lets the next item enter while a result is still pending on m_.
module contiguous_frame_bitmap_allocator (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic                            s_op,
    input  logic [cfba_pkg::CNT_W-1:0]      s_count,
    input  logic [cfba_pkg::ADDR_W-1:0]     s_address,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [1:0]                      m_status,
    output logic [cfba_pkg::OUT_ADDR_W-1:0] m_frame_address,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [cfba_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [cfba_pkg::ADDR_W-1:0]     cfg_data
);
    import cfba_pkg::*;

    state_t                 state_reg, state_next;
    rng_mode_t              mode_reg, mode_next;
    logic [WORD_AW-1:0]     clr_reg, clr_next;
    logic [WORD_AW-1:0]     rd_word_reg, rd_word_next;
    logic [WORD_AW-1:0]     proc_word_reg, proc_word_next;
    logic                   dval_reg, dval_next;
    logic [WORD_AW-1:0]     scan_last_reg, scan_last_next;
    logic [CNT_W-1:0]       run_reg, run_next;
    logic [CNT_W-1:0]       cnt_reg, cnt_next;
    logic [FRAME_IW-1:0]    first_reg, first_next;
    logic [FRAME_IW-1:0]    last_reg, last_next;
    logic [WORD_AW-1:0]     rng_word_reg, rng_word_next;
    status_t                stat_reg, stat_next;
    logic [OUT_ADDR_W-1:0]  res_addr_reg, res_addr_next;
    logic [ADDR_W-1:0]      base_reg;
    logic [CNT_W-1:0]       fcount_reg;
    logic                   m_valid_reg;
    logic [1:0]             m_status_reg;
    logic [OUT_ADDR_W-1:0]  m_addr_reg;

    mem_req_t               mem_req;
    logic [WORD_BITS-1:0]   rd_data;
    logic [WORD_BITS-1:0]   word_used;
    logic [WORD_BITS-1:0]   rng_mask;
    run_res_t               run_res;

    logic [CNT_W-1:0]       n_eff;
    logic [CNT_W-1:0]       rem;
    logic [ADDR_W-1:0]      offset;
    logic [FIDX_W-1:0]      fidx;
    logic                   bad_addr;
    logic                   past_end;
    logic [FRAME_IW-1:0]    free_last;
    logic [FRAME_IW-1:0]    hit_first;
    logic [WORD_IW-1:0]     lo_bit;
    logic [WORD_IW-1:0]     hi_bit;
    logic                   rng_at_last;
    logic                   accept;

    assign n_eff = (fcount_reg > MAX_FRAMES_C) ? MAX_FRAMES_C : fcount_reg;

    // Free request decode
    assign offset    = (s_address | KERNEL_BIT) - base_reg;
    assign fidx      = offset[ADDR_W-2:FRAME_SHIFT];
    assign bad_addr  = offset[ADDR_W-1] || (|offset[FRAME_SHIFT-1:0]);
    assign past_end  = (fidx > FIDX_W'(n_eff)) || (s_count > (n_eff - CNT_W'(fidx)));
    assign free_last = fidx[FRAME_IW-1:0] + FRAME_IW'(s_count) - FRAME_IW'(1);

    // Frames at or past the frame count read as used during the scan
    assign rem = n_eff - CNT_W'({proc_word_reg, {WORD_IW{1'b0}}});
    always_comb begin
        for (int b = 0; b < WORD_BITS; b++) begin
            word_used[b] = rd_data[b] | (CNT_W'(b) >= rem);
        end
    end

    cfba_run_finder u_run_finder (
        .used   (word_used),
        .run_in (run_reg),
        .count  (cnt_reg),
        .res    (run_res)
    );

    assign hit_first = FRAME_IW'(CNT_W'({proc_word_reg, run_res.hit_pos}) + CNT_W'(1) - cnt_reg);

    // Per-word mask of the frames in [first, last]
    assign rng_at_last = (rng_word_reg == last_reg[FRAME_IW-1:WORD_IW]);
    assign lo_bit = (rng_word_reg == first_reg[FRAME_IW-1:WORD_IW]) ? first_reg[WORD_IW-1:0] : '0;
    assign hi_bit = rng_at_last ? last_reg[WORD_IW-1:0] : {WORD_IW{1'b1}};
    assign rng_mask = ({WORD_BITS{1'b1}} << lo_bit)
                    & ({WORD_BITS{1'b1}} >> ({WORD_IW{1'b1}} - hi_bit));

    cfba_bitmap_ram u_bitmap (
        .aclk    (aclk),
        .req     (mem_req),
        .rd_data (rd_data)
    );

    assign accept = s_valid && s_ready;

    // Next state
    always_comb begin
        state_next     = state_reg;
        mode_next      = mode_reg;
        clr_next       = clr_reg;
        rd_word_next   = rd_word_reg;
        proc_word_next = proc_word_reg;
        dval_next      = 1'b0;
        scan_last_next = scan_last_reg;
        run_next       = run_reg;
        cnt_next       = cnt_reg;
        first_next     = first_reg;
        last_next      = last_reg;
        rng_word_next  = rng_word_reg;
        stat_next      = stat_reg;
        res_addr_next  = res_addr_reg;
        case (state_reg)
            ST_CLEAR: begin
                clr_next = clr_reg + WORD_AW'(1);
                if (clr_reg == {WORD_AW{1'b1}}) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (accept) begin
                    cnt_next      = s_count;
                    res_addr_next = '0;
                    if (s_op == OP_ALLOC) begin
                        if (s_count == '0 || s_count > n_eff) begin
                            stat_next  = STAT_NOMEM;
                            state_next = ST_RESP;
                        end else begin
                            rd_word_next   = '0;
                            run_next       = '0;
                            scan_last_next = WORD_AW'((n_eff - CNT_W'(1)) >> WORD_IW);
                            state_next     = ST_SCAN;
                        end
                    end else begin
                        if (bad_addr) begin
                            stat_next  = STAT_BADADDR;
                            state_next = ST_RESP;
                        end else if (past_end) begin
                            stat_next  = STAT_NOTALLOC;
                            state_next = ST_RESP;
                        end else if (s_count == '0) begin
                            stat_next  = STAT_OK;
                            state_next = ST_RESP;
                        end else begin
                            first_next    = fidx[FRAME_IW-1:0];
                            last_next     = free_last;
                            rng_word_next = fidx[FRAME_IW-1:WORD_IW];
                            mode_next     = RNG_CHECK;
                            state_next    = ST_RNG_RD;
                        end
                    end
                end
            end
            ST_SCAN: begin
                // stream one word a cycle; data lands in the cycle after its read
                rd_word_next   = rd_word_reg + WORD_AW'(1);
                proc_word_next = rd_word_reg;
                dval_next      = 1'b1;
                if (dval_reg) begin
                    if (run_res.hit) begin
                        first_next    = hit_first;
                        last_next     = {proc_word_reg, run_res.hit_pos};
                        rng_word_next = hit_first[FRAME_IW-1:WORD_IW];
                        mode_next     = RNG_SET;
                        stat_next     = STAT_OK;
                        dval_next     = 1'b0;
                        state_next    = ST_RNG_RD;
                    end else if (proc_word_reg == scan_last_reg) begin
                        stat_next  = STAT_NOMEM;
                        dval_next  = 1'b0;
                        state_next = ST_RESP;
                    end else if (run_res.all_free) begin
                        run_next = run_reg + CNT_W'(WORD_BITS);
                    end else begin
                        run_next = CNT_W'(run_res.tail_run);
                    end
                end
            end
            ST_RNG_RD: begin
                state_next = ST_RNG_OP;
            end
            ST_RNG_OP: begin
                state_next = ST_RNG_RD;
                if (mode_reg == RNG_CHECK) begin
                    if (|(~rd_data & rng_mask)) begin
                        stat_next  = STAT_NOTALLOC;
                        state_next = ST_RESP;
                    end else if (rng_at_last) begin
                        mode_next     = RNG_CLEAR;
                        rng_word_next = first_reg[FRAME_IW-1:WORD_IW];
                    end else begin
                        rng_word_next = rng_word_reg + WORD_AW'(1);
                    end
                end else if (rng_at_last) begin
                    stat_next  = STAT_OK;
                    state_next = ST_RESP;
                    if (mode_reg == RNG_SET) begin
                        res_addr_next = OUT_ADDR_W'(base_reg
                                      + (ADDR_W'(first_reg) << FRAME_SHIFT));
                    end
                end else begin
                    rng_word_next = rng_word_reg + WORD_AW'(1);
                end
            end
            ST_RESP: begin
                // wait for the result register to drain
                if (!m_valid_reg || m_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Outputs
    always_comb begin
        s_ready         = 1'b0;
        mem_req.rd_en   = 1'b0;
        mem_req.rd_addr = rng_word_reg;
        mem_req.wr_en   = 1'b0;
        mem_req.wr_addr = rng_word_reg;
        mem_req.wr_data = rd_data | rng_mask;
        case (state_reg)
            ST_CLEAR: begin
                mem_req.wr_en   = 1'b1;
                mem_req.wr_addr = clr_reg;
                mem_req.wr_data = '0;
            end
            ST_IDLE: begin
                s_ready = 1'b1;
            end
            ST_SCAN: begin
                mem_req.rd_en   = 1'b1;
                mem_req.rd_addr = rd_word_reg;
            end
            ST_RNG_RD: begin
                mem_req.rd_en = 1'b1;
            end
            ST_RNG_OP: begin
                if (mode_reg == RNG_SET) begin
                    mem_req.wr_en = 1'b1;
                end else if (mode_reg == RNG_CLEAR) begin
                    mem_req.wr_en   = 1'b1;
                    mem_req.wr_data = rd_data & ~rng_mask;
                end
            end
            default: begin
                s_ready = 1'b0;
            end
        endcase
    end

    assign cfg_ready       = 1'b1;
    assign m_valid         = m_valid_reg;
    assign m_status        = m_status_reg;
    assign m_frame_address = m_addr_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLEAR;
            mode_reg    <= RNG_CHECK;
            clr_reg     <= '0;
            dval_reg    <= 1'b0;
            base_reg    <= BASE_RESET;
            fcount_reg  <= FCOUNT_RESET;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            mode_reg  <= mode_next;
            clr_reg   <= clr_next;
            dval_reg  <= dval_next;
            if (cfg_valid && cfg_ready) begin
                if (cfg_index == CFG_BASE) begin
                    base_reg <= cfg_data;
                end else if (cfg_index == CFG_FCOUNT) begin
                    fcount_reg <= cfg_data[CNT_W-1:0];
                end
            end
            if (state_reg == ST_RESP && (!m_valid_reg || m_ready)) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        rd_word_reg   <= rd_word_next;
        proc_word_reg <= proc_word_next;
        scan_last_reg <= scan_last_next;
        run_reg       <= run_next;
        cnt_reg       <= cnt_next;
        first_reg     <= first_next;
        last_reg      <= last_next;
        rng_word_reg  <= rng_word_next;
        stat_reg      <= stat_next;
        res_addr_reg  <= res_addr_next;
        if (state_reg == ST_RESP && (!m_valid_reg || m_ready)) begin
            m_status_reg <= stat_reg;
            m_addr_reg   <= res_addr_reg;
        end
    end

`ifndef ASSERT_OFF
    a_no_write_in_scan: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SCAN) |-> !mem_req.wr_en)
        else $error("bitmap written during scan");

    a_rng_word_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_RNG_OP) |-> (rng_word_reg <= last_reg[FRAME_IW-1:WORD_IW]))
        else $error("range pass ran past its last word");

    a_scan_word_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SCAN && dval_reg) |-> (proc_word_reg <= scan_last_reg))
        else $error("scan processed a word past the frame count");

    a_range_order: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_RNG_RD) |-> (first_reg <= last_reg))
        else $error("range pass with first frame above last");

    a_result_load: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_RESP && (!m_valid_reg || m_ready)) |=> m_valid_reg)
        else $error("result not presented after completion");
`endif

endmodule

@@ bench/cfba_checker.sv @@
// Result checker for the frame allocator: mirrors the bitmap and compares each result.
`timescale 1ns / 1ps

module cfba_checker (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_valid,
    input  logic                             s_ready,
    input  logic                             s_op,
    input  logic [cfba_pkg::CNT_W-1:0]       s_count,
    input  logic [cfba_pkg::ADDR_W-1:0]      s_address,
    input  logic                             m_valid,
    input  logic                             m_ready,
    input  logic [1:0]                       m_status,
    input  logic [cfba_pkg::OUT_ADDR_W-1:0]  m_frame_address,
    input  logic                             cfg_valid,
    input  logic                             cfg_ready,
    input  logic [cfba_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [cfba_pkg::ADDR_W-1:0]      cfg_data,
    output int                               mismatch_count,
    output int                               pending_results
);
    import cfba_pkg::*;

    typedef struct packed {
        status_t                status;
        logic [OUT_ADDR_W-1:0]  addr;
    } frame_result_t;

    logic              frame_used [MAX_FRAMES];
    logic [ADDR_W-1:0] base_reg;
    logic [CNT_W-1:0]  fcount_reg;
    frame_result_t     expected_results [$];
    int                fail_total;

    // Apply one request to the mirrored bitmap and return the result it must produce.
    function automatic frame_result_t predict_request(input logic op,
                                                      input logic [CNT_W-1:0] frames,
                                                      input logic [ADDR_W-1:0] phys);
        frame_result_t     res;
        int unsigned       active;
        int unsigned       run_len;
        int unsigned       first;
        int unsigned       idx;
        logic              found;
        logic              in_use;
        logic [ADDR_W-1:0] offset;
        logic [ADDR_W-1:0] start_addr;
        res.status = STAT_NOMEM;
        res.addr   = '0;
        active     = (fcount_reg > MAX_FRAMES_C) ? MAX_FRAMES : int'(fcount_reg);
        if (op == OP_ALLOC) begin
            if (frames != '0 && frames <= active) begin
                run_len = 0;
                found   = 1'b0;
                first   = 0;
                for (int i = 0; i < int'(active) && !found; i++) begin
                    run_len = frame_used[i] ? 0 : run_len + 1;
                    if (run_len == frames) begin
                        found = 1'b1;
                        first = i + 1 - frames;
                    end
                end
                if (found) begin
                    for (int j = int'(first); j < int'(first + frames); j++)
                        frame_used[j] = 1'b1;
                    start_addr = base_reg + (ADDR_W'(first) << FRAME_SHIFT);
                    res.status = STAT_OK;
                    res.addr   = start_addr[OUT_ADDR_W-1:0];
                end
            end
        end else begin
            offset = (phys | KERNEL_BIT) - base_reg;
            if (offset[ADDR_W-1] || offset[FRAME_SHIFT-1:0] != '0) begin
                res.status = STAT_BADADDR;
            end else begin
                idx = offset >> FRAME_SHIFT;
                if (idx > active || frames > active - idx) begin
                    res.status = STAT_NOTALLOC;
                end else begin
                    in_use = 1'b1;
                    for (int j = 0; j < int'(frames); j++)
                        if (!frame_used[idx + j]) in_use = 1'b0;
                    if (in_use) begin
                        for (int j = 0; j < int'(frames); j++)
                            frame_used[idx + j] = 1'b0;
                        res.status = STAT_OK;
                    end else begin
                        res.status = STAT_NOTALLOC;
                    end
                end
            end
        end
        return res;
    endfunction

    always @(posedge aclk) begin
        frame_result_t expected;
        if (!aresetn) begin
            for (int i = 0; i < MAX_FRAMES; i++)
                frame_used[i] = 1'b0;
            base_reg   = BASE_RESET;
            fcount_reg = FCOUNT_RESET;
            fail_total = 0;
            expected_results.delete();
        end else begin
            if (cfg_valid && cfg_ready) begin
                if (cfg_index == CFG_BASE)
                    base_reg = cfg_data;
                else if (cfg_index == CFG_FCOUNT)
                    fcount_reg = cfg_data[CNT_W-1:0];
            end
            // Retire before predicting: a result never belongs to the request taken this edge.
            if (m_valid && m_ready) begin
                if (expected_results.size() == 0) begin
                    $display("%0t: unexpected result: expected none, actual status %0d addr 0x%08h",
                             $time, m_status, m_frame_address);
                    fail_total++;
                end else begin
                    expected = expected_results.pop_front();
                    if (m_status !== expected.status) begin
                        $display("%0t: status mismatch: expected %0d, actual %0d",
                                 $time, expected.status, m_status);
                        fail_total++;
                    end
                    if (m_frame_address !== expected.addr) begin
                        $display("%0t: frame address mismatch: expected 0x%08h, actual 0x%08h",
                                 $time, expected.addr, m_frame_address);
                        fail_total++;
                    end
                end
            end
            if (s_valid && s_ready)
                expected_results.push_back(predict_request(s_op, s_count, s_address));
        end
        mismatch_count  <= fail_total;
        pending_results <= expected_results.size();
    end

endmodule

@@ bench/testbench.sv @@
// Testbench top: reset, stimulus, handshake pacing and the final verdict for the allocator.
`timescale 1ns / 1ps

module testbench;
    import cfba_pkg::*;

    localparam int WATCHDOG_LIMIT = 10000;
    localparam int SETTLE_CYCLES  = 600;
    localparam int SEGMENT_ITEMS  = 230;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

    typedef struct packed {
        logic             op;
        logic [CNT_W-1:0] frames;
    } request_t;

    typedef struct packed {
        logic [OUT_ADDR_W-1:0] addr;
        logic [CNT_W-1:0]      frames;
    } frame_run_t;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  s_valid = 1'b0;
    logic                  s_ready;
    logic                  s_op = OP_ALLOC;
    logic [CNT_W-1:0]      s_count = '0;
    logic [ADDR_W-1:0]     s_address = '0;
    logic                  m_valid;
    logic                  m_ready = 1'b0;
    logic [1:0]            m_status;
    logic [OUT_ADDR_W-1:0] m_frame_address;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [ADDR_W-1:0]     cfg_data = '0;
    int                    mismatch_count;
    int                    pending_results;

    int                    send_idle_pct = 10;
    int                    recv_idle_pct = 85;
    int                    idle_cycles = 0;
    int                    sent_total = 0;
    int                    cfg_total = 0;
    int                    status_seen [4] = '{0, 0, 0, 0};
    request_t              inflight_reqs [$];
    frame_run_t            live_runs [$];
    frame_run_t            released_runs [$];
    logic [ADDR_W-1:0]     cur_base = BASE_RESET;
    int                    cur_active = MAX_FRAMES;

    contiguous_frame_bitmap_allocator i_dut (.*);

    cfba_checker i_checker (.*);

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    always @(posedge aclk)
        m_ready <= ($urandom_range(99) >= recv_idle_pct);

    // Track results to learn which runs are live, and watch for a hang.
    always @(posedge aclk) begin
        request_t req;
        if (aresetn && m_valid && m_ready) begin
            status_seen[m_status]++;
            if (inflight_reqs.size() != 0) begin
                req = inflight_reqs.pop_front();
                if (req.op == OP_ALLOC && m_status == STAT_OK)
                    live_runs.push_back('{m_frame_address, req.frames});
            end
        end
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no transfer for %0d cycles", $time, WATCHDOG_LIMIT);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    task automatic send_request(input logic op, input logic [CNT_W-1:0] frames,
                                input logic [ADDR_W-1:0] phys);
        int gap;
        gap = 0;
        while (gap < 40 && $urandom_range(99) < send_idle_pct)
            gap++;
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid   <= 1'b1;
        s_op      <= op;
        s_count   <= frames;
        s_address <= phys;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        inflight_reqs.push_back('{op, frames});
        sent_total++;
    endtask

    // Hold the sender until every outstanding result has been delivered.
    task automatic drain_results();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending_results != 0) @(posedge aclk);
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [ADDR_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_total++;
    endtask

    task automatic configure(input logic [ADDR_W-1:0] base, input logic [CNT_W-1:0] frames);
        drain_results();
        write_register(CFG_BASE, base);
        write_register(CFG_FCOUNT, frames);
        cfg_valid <= 1'b0;
        cur_base   = base;
        cur_active = (frames > MAX_FRAMES_C) ? MAX_FRAMES : int'(frames);
        live_runs.delete();
        released_runs.delete();
    endtask

    task automatic release_run(input frame_run_t run);
        send_request(OP_FREE, run.frames, {1'($urandom_range(1)), run.addr});
        released_runs.push_back(run);
        if (released_runs.size() > 16)
            void'(released_runs.pop_front());
    endtask

    // Free every run still held so the next setting starts from a clean map.
    task automatic release_all();
        drain_results();
        while (live_runs.size() != 0)
            release_run(live_runs.pop_front());
    endtask

    function automatic logic [CNT_W-1:0] pick_alloc_count(input int active);
        int r;
        r = $urandom_range(99);
        if (r < 65)
            return CNT_W'($urandom_range(8, 1));
        if (r < 85)
            return CNT_W'($urandom_range(64, 9));
        if (r < 92)
            return CNT_W'($urandom_range(active > 1 ? active : 1, 1));
        case ($urandom_range(5))
            0:       return '0;
            1:       return CNT_W'(MAX_FRAMES);
            2:       return '1;
            3:       return CNT_W'($urandom_range(8191));
            4:       return CNT_W'(active);
            default: return CNT_W'(active + 1);
        endcase
    endfunction

    task automatic send_random_item();
        int         r;
        int         i;
        int         k;
        int         free_pct;
        frame_run_t run;
        r        = $urandom_range(99);
        free_pct = (live_runs.size() > 30) ? 55 : 35;
        if (live_runs.size() != 0 && r < free_pct) begin
            i   = $urandom_range(live_runs.size() - 1);
            run = live_runs[i];
            if (run.frames > 1 && $urandom_range(3) == 0) begin
                // Split the run: free its tail, keep the head live.
                k = $urandom_range(int'(run.frames) - 1, 1);
                live_runs[i] = '{run.addr, CNT_W'(k)};
                send_request(OP_FREE, run.frames - CNT_W'(k),
                             {1'($urandom_range(1)),
                              run.addr + OUT_ADDR_W'(k << FRAME_SHIFT)});
            end else begin
                live_runs.delete(i);
                release_run(run);
            end
        end else if (r < free_pct + 10) begin
            case ($urandom_range(4))
                0: send_request(OP_FREE, CNT_W'($urandom_range(8191)), $urandom);
                1: begin
                    if (live_runs.size() != 0)
                        run = live_runs[$urandom_range(live_runs.size() - 1)];
                    else
                        run = '{cur_base[OUT_ADDR_W-1:0], CNT_W'(1)};
                    send_request(OP_FREE, 1, {1'b0, run.addr} + $urandom_range(4095, 1));
                end
                2: begin
                    if (released_runs.size() != 0)
                        run = released_runs[$urandom_range(released_runs.size() - 1)];
                    else
                        run = '{cur_base[OUT_ADDR_W-1:0], CNT_W'(2)};
                    send_request(OP_FREE, run.frames, {1'b0, run.addr});
                end
                3: send_request(OP_FREE, CNT_W'($urandom_range(16)),
                                cur_base + (ADDR_W'($urandom_range(cur_active + 2))
                                            << FRAME_SHIFT));
                default: send_request(OP_FREE, '0,
                                      cur_base + (ADDR_W'($urandom_range(cur_active + 4))
                                                  << FRAME_SHIFT));
            endcase
        end else begin
            send_request(OP_ALLOC, pick_alloc_count(cur_active), $urandom);
        end
    endtask

    initial begin
        logic [ADDR_W-1:0] seg_base;
        logic [CNT_W-1:0]  seg_frames;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed: first-fit order, full map, holes and every free error path.
        send_request(OP_ALLOC, 0, 32'h0);
        send_request(OP_ALLOC, 1, 32'hffff_ffff);
        send_request(OP_ALLOC, CNT_W'(MAX_FRAMES), 32'h0);
        send_request(OP_FREE, 1, 32'h0000_0000);
        send_request(OP_ALLOC, CNT_W'(MAX_FRAMES), 32'h0);
        send_request(OP_FREE, CNT_W'(MAX_FRAMES), 32'h8000_0000);
        send_request(OP_ALLOC, 3, 32'h0);
        send_request(OP_ALLOC, 2, 32'h0);
        send_request(OP_FREE, 1, 32'h0000_1000);
        send_request(OP_ALLOC, 2, 32'h0);
        send_request(OP_ALLOC, 1, 32'h0);
        send_request(OP_FREE, 1, 32'h7fff_ffff);
        send_request(OP_FREE, 1, 32'hffff_f000);
        send_request(OP_FREE, 2, 32'h00ff_f000);
        send_request(OP_FREE, 1, 32'h0000_8000);
        send_request(OP_FREE, 7, 32'h0000_0000);
        send_request(OP_FREE, 0, 32'h0100_0000);
        send_request(OP_FREE, 0, 32'h0100_1000);

        // Directed: base and frame count corners.
        configure(32'h9000_0000, CNT_W'(MAX_FRAMES));
        send_request(OP_FREE, 1, 32'h0);
        send_request(OP_ALLOC, 1, 32'h0);
        configure(32'hffff_f000, '0);
        send_request(OP_ALLOC, 1, 32'h0);
        send_request(OP_FREE, 1, 32'h7fff_f000);
        send_request(OP_FREE, 0, 32'h7fff_f000);
        configure(32'hffff_f000, '1);
        send_request(OP_ALLOC, 2, 32'h0);
        configure(32'h0, CNT_W'(MAX_FRAMES));
        send_request(OP_ALLOC, 1, 32'h0);
        send_request(OP_FREE, 1, 32'h0000_3000);
        configure(32'hffff_ffff, 1);
        write_register(CFG_SPARE, 32'h0000_0001);
        cfg_valid <= 1'b0;
        send_request(OP_FREE, 1, 32'h7fff_ffff);
        configure(BASE_RESET, FCOUNT_RESET);
        send_request(OP_FREE, 3, 32'h0000_1000);

        for (int seg = 0; seg < 6; seg++) begin
            send_idle_pct = (seg < 2) ? 10 : (seg < 4) ? 85 : 0;
            recv_idle_pct = (seg < 2) ? 85 : (seg < 4) ? 10 : 0;
            case (seg)
                0: begin seg_base = BASE_RESET; seg_frames = FCOUNT_RESET; end
                1: begin seg_base = {1'b1, 19'($urandom), 12'h0}; seg_frames = 64; end
                2: begin seg_base = 32'hffff_f000; seg_frames = 1; end
                3: begin
                    seg_base   = {1'b1, 19'($urandom), 12'h0};
                    seg_frames = CNT_W'($urandom_range(4096, 65));
                end
                4: begin seg_base = BASE_RESET; seg_frames = '1; end
                default: begin
                    seg_base   = $urandom;
                    seg_frames = CNT_W'($urandom_range(8191));
                end
            endcase
            release_all();
            configure(seg_base, seg_frames);
            for (int n = 0; n < SEGMENT_ITEMS; n++) begin
                if ($urandom_range(199) == 0)
                    drain_results();
                send_random_item();
            end
        end
        release_all();

        drain_results();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        $display("Ran %0d requests and %0d register writes across six base/frame-count settings",
                 sent_total, cfg_total);
        $display("and three pacing modes; results: %0d ok, %0d no memory,",
                 status_seen[STAT_OK], status_seen[STAT_NOMEM]);
        $display("%0d bad address, %0d not allocated.",
                 status_seen[STAT_BADADDR], status_seen[STAT_NOTALLOC]);
        if (mismatch_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

@@ sim.f @@
src/cfba_pkg.sv
src/cfba_bitmap_ram.sv
src/cfba_run_finder.sv
src/contiguous_frame_bitmap_allocator.sv
bench/cfba_checker.sv
bench/testbench.sv
